FILE: design/cwtf_pkg.sv
// ============================================================================
// cwtf_pkg
// Shared constants, types and register indexes for the traffic feature unit.
// ============================================================================
package cwtf_pkg;

	localparam int HistDepth  = 1024;
	localparam int SlotW      = $clog2(HistDepth);
	localparam int FracBits   = 16;
	localparam int RateW      = FracBits + 1;
	localparam int TallyW     = SlotW + 1;
	localparam int CountW     = 10;
	localparam int DivW       = TallyW + FracBits;

	localparam logic [1:0] CfgTimeSpan  = 2'd0;
	localparam logic [1:0] CfgCountLen  = 2'd1;
	localparam logic [1:0] CfgOtherSvc  = 2'd2;

	localparam logic [1:0] FlagSynErr   = 2'd1;
	localparam logic [1:0] FlagReject   = 2'd2;

	// one history entry as stored in memory
	typedef struct packed {
		logic [31:0] tsec;
		logic [31:0] host;
		logic [15:0] dport;
		logic [15:0] sport;
		logic [7:0]  svc;
		logic [1:0]  flag;
	} hist_entry_t;

	typedef struct packed {
		logic [TallyW-1:0] host;
		logic [TallyW-1:0] port;
		logic [TallyW-1:0] serr;
		logic [TallyW-1:0] rej;
		logic [TallyW-1:0] svc_match;
		logic [TallyW-1:0] svc_miss;
		logic [TallyW-1:0] port_serr;
		logic [TallyW-1:0] port_rej;
		logic [TallyW-1:0] port_diff_host;
		logic [TallyW-1:0] same_src;
	} tally_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TSCAN,
		ST_CSCAN,
		ST_DRAIN,
		ST_DIV,
		ST_OUT0,
		ST_OUT1
	} state_t;

endpackage

FILE: design/cwtf_hist_ram.sv
// ============================================================================
// cwtf_hist_ram
// History ring memory: one write port, one registered read port.
// ============================================================================
module cwtf_hist_ram
	import cwtf_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [SlotW-1:0]  waddr,
	input  hist_entry_t       wdata,
	input  logic [SlotW-1:0]  raddr,
	output hist_entry_t       rdata
);

	hist_entry_t mem [HistDepth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/cwtf_divider.sv
// ============================================================================
// cwtf_divider
// Restoring divider: (num << FracBits) / den, one quotient bit a cycle.
// ============================================================================
module cwtf_divider
	import cwtf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [TallyW-1:0] num,
	input  logic [TallyW-1:0] den,
	output logic              done,
	output logic [RateW-1:0]  quot
);

	localparam int CntW = $clog2(DivW + 1);

	logic [DivW-1:0]   dividend_q;
	logic [TallyW:0]   rem_q;
	logic [TallyW-1:0] den_q;
	logic [CntW-1:0]   cnt_q;
	logic              busy_q;
	logic              zero_q;
	logic [TallyW:0]   rem_sh;
	logic [TallyW:0]   rem_sub;

	assign rem_sh  = {rem_q[TallyW-1:0], dividend_q[DivW-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= !start && busy_q && (cnt_q == CntW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(DivW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dividend_q <= {num, {FracBits{1'b0}}};
			rem_q      <= '0;
			den_q      <= den;
			zero_q     <= (den == '0);
		end else if (busy_q) begin
			if (!rem_sub[TallyW]) begin
				rem_q      <= rem_sub;
				dividend_q <= {dividend_q[DivW-2:0], 1'b1};
			end else begin
				rem_q      <= rem_sh;
				dividend_q <= {dividend_q[DivW-2:0], 1'b0};
			end
		end
	end

	// quotient has shifted into the dividend register
	assign quot = zero_q ? '0 : dividend_q[RateW-1:0];

endmodule

FILE: design/connection_window_traffic_features_unit.sv
// ============================================================================
// connection_window_traffic_features_unit
// Time and count window traffic features over a ring of past connections.
// ============================================================================
// Usage: present a connection record on the input channel (valid/ready). The
// unit scans the history memory one entry a cycle: first the tracked time
// range from its oldest slot to the newest record (up to 1024 entries), then
// the last N records of the count window. The memory read port is registered.
// It then runs eighteen divisions on one shared bit-serial divider, each a
// start, one shift step per dividend bit (DivW, 27 at the default widths)
// and a capture of the quotient. Two results follow on
// the output channel: the time window set, then the count window set with
// last_of_run high. One record is worked on at a time: no new record is
// accepted until both results have been taken. The output channel holds a
// result until it is taken; a stalled receiver simply holds the unit in its
// output state. Reset clears the ring pointers and restores register
// defaults; history contents are not cleared and are only read after being
// written. Configuration writes must only occur while the unit is idle.
// ============================================================================
module connection_window_traffic_features_unit
	import cwtf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [9:0]           cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [31:0]          start_seconds,
	input  logic [31:0]          dest_host,
	input  logic [15:0]          dest_port,
	input  logic [15:0]          src_port,
	input  logic [7:0]           service_code,
	input  logic [1:0]           flag_class,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 window_kind,
	output logic [CountW-1:0]    host_count,
	output logic [CountW-1:0]    port_count,
	output logic [RateW-1:0]     syn_error_rate,
	output logic [RateW-1:0]     port_syn_error_rate,
	output logic [RateW-1:0]     reject_rate,
	output logic [RateW-1:0]     port_reject_rate,
	output logic [RateW-1:0]     same_service_rate,
	output logic [RateW-1:0]     diff_service_rate,
	output logic [RateW-1:0]     port_diff_host_rate,
	output logic [RateW-1:0]     src_port_match_rate,
	output logic                 last_of_run
);

	localparam int NumDiv = 18;
	localparam int DivIdxW = $clog2(NumDiv);

	// configuration
	logic [7:0] span_q;
	logic [9:0] clen_q;
	logic [7:0] other_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q  <= 8'd2;
			clen_q  <= 10'd100;
			other_q <= 8'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CfgTimeSpan: span_q  <= cfg_data[7:0];
				CfgCountLen: clen_q  <= cfg_data;
				CfgOtherSvc: other_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// control state
	state_t            state_q, state_d;
	logic [SlotW-1:0]  wslot_q;
	logic [TallyW-1:0] stored_q;
	logic [SlotW-1:0]  tstart_q;
	logic [SlotW-1:0]  nstart_q;
	logic              found_q;
	logic [TallyW-1:0] left_q;
	logic [SlotW-1:0]  raddr_q;
	logic [TallyW-1:0] ktot_q;
	logic              rd_s1;
	logic              rdtime_s1;
	logic [SlotW-1:0]  rslot_s1;
	logic [DivIdxW-1:0] didx_q;
	logic              dbusy_q;

	hist_entry_t cur_q;
	tally_t      tw_q, cw_q;
	logic [RateW-1:0] rate_q [NumDiv];

	hist_entry_t rdata;
	hist_entry_t wdata;
	logic        store;

	assign wdata = '{tsec: start_seconds, host: dest_host, dport: dest_port,
		sport: src_port, svc: service_code, flag: flag_class};

	cwtf_hist_ram u_ram (
		.clk   (clk),
		.we    (store),
		.waddr (wslot_q),
		.wdata (cur_q),
		.raddr (raddr_q),
		.rdata (rdata)
	);

	// scan lengths
	logic [TallyW-1:0] tlen;
	logic [TallyW-1:0] klen;
	logic [SlotW-1:0]  kfirst;
	assign tlen   = (stored_q == '0) ? '0 :
		{1'b0, SlotW'(wslot_q - tstart_q - 1'b1)} + 1'b1;
	assign klen   = ({1'b0, clen_q} < stored_q) ? TallyW'(clen_q) : stored_q;
	assign kfirst = wslot_q - klen[SlotW-1:0];

	// time window membership of the entry read last cycle
	logic [32:0] upper;
	logic        in_tw;
	assign upper = {1'b0, rdata.tsec} + 33'(span_q);
	assign in_tw = (rdata.tsec <= cur_q.tsec) && (upper >= {1'b0, cur_q.tsec});

	// compare entry with current record
	logic same_host, same_port, same_src;
	assign same_host = rdata.host == cur_q.host;
	assign same_port = rdata.dport == cur_q.dport;
	assign same_src  = rdata.sport == cur_q.sport;

	function automatic tally_t tally_add(tally_t t, hist_entry_t e, hist_entry_t c,
		logic sh, logic sp, logic ss, logic [7:0] oth);
		tally_t r;
		r = t;
		if (sh) begin
			r.host = t.host + 1'b1;
			if (e.flag == FlagSynErr) r.serr = t.serr + 1'b1;
			if (e.flag == FlagReject) r.rej = t.rej + 1'b1;
			if (e.svc != oth && e.svc == c.svc) r.svc_match = t.svc_match + 1'b1;
			if (e.svc != c.svc) r.svc_miss = t.svc_miss + 1'b1;
		end
		if (sp) begin
			r.port = t.port + 1'b1;
			if (e.flag == FlagSynErr) r.port_serr = t.port_serr + 1'b1;
			if (e.flag == FlagReject) r.port_rej = t.port_rej + 1'b1;
			if (!sh) r.port_diff_host = t.port_diff_host + 1'b1;
		end
		if (ss) r.same_src = t.same_src + 1'b1;
		return r;
	endfunction

	// divider operand select
	logic [TallyW-1:0] dnum, dden;
	always_comb begin
		unique case (didx_q)
			5'd0:  begin dnum = tw_q.serr;           dden = tw_q.host; end
			5'd1:  begin dnum = tw_q.port_serr;      dden = tw_q.port; end
			5'd2:  begin dnum = tw_q.rej;            dden = tw_q.host; end
			5'd3:  begin dnum = tw_q.port_rej;       dden = tw_q.port; end
			5'd4:  begin dnum = tw_q.svc_match;      dden = tw_q.host; end
			5'd5:  begin dnum = tw_q.svc_miss;       dden = tw_q.host; end
			5'd6:  begin dnum = tw_q.port_diff_host; dden = tw_q.port; end
			5'd7:  begin dnum = cw_q.same_src;       dden = ktot_q;    end
			5'd8:  begin dnum = cw_q.serr;           dden = cw_q.host; end
			5'd9:  begin dnum = cw_q.port_serr;      dden = cw_q.port; end
			5'd10: begin dnum = cw_q.rej;            dden = cw_q.host; end
			5'd11: begin dnum = cw_q.port_rej;       dden = cw_q.port; end
			5'd12: begin dnum = cw_q.svc_match;      dden = cw_q.host; end
			5'd13: begin dnum = cw_q.svc_miss;       dden = cw_q.host; end
			5'd14: begin dnum = cw_q.port_diff_host; dden = cw_q.port; end
			default: begin dnum = '0;                dden = '0;        end
		endcase
	end

	logic             dstart, ddone;
	logic [RateW-1:0] dquot;
	cwtf_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dstart),
		.num    (dnum),
		.den    (dden),
		.done   (ddone),
		.quot   (dquot)
	);

	logic last_issue;
	assign last_issue = didx_q == DivIdxW'(NumDiv - 1);

	// next state
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		dstart   = 1'b0;
		store    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = ST_TSCAN;
			end
			ST_TSCAN: if (left_q == '0) state_d = ST_CSCAN;
			ST_CSCAN: if (left_q == '0) state_d = ST_DRAIN;
			ST_DRAIN: if (!rd_s1) begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				dstart = !dbusy_q;
				if (ddone && last_issue) state_d = ST_OUT0;
			end
			ST_OUT0: if (out_ready) state_d = ST_OUT1;
			ST_OUT1: if (out_ready) begin
				state_d = ST_IDLE;
				store   = 1'b1;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// a memory read is issued in every scan cycle with entries left
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= ((state_q == ST_TSCAN) || (state_q == ST_CSCAN)) && (left_q != '0);
		end
	end

	// datapath and sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wslot_q   <= '0;
			stored_q  <= '0;
			tstart_q  <= '0;
			nstart_q  <= '0;
			found_q   <= 1'b0;
			left_q    <= '0;
			raddr_q   <= '0;
			ktot_q    <= '0;
			rdtime_s1 <= 1'b0;
			rslot_s1  <= '0;
			didx_q    <= '0;
			dbusy_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid) begin
					left_q   <= tlen;
					raddr_q  <= tstart_q;
					nstart_q <= tstart_q;
					found_q  <= 1'b0;
				end
				ST_TSCAN: begin
					if (left_q == '0) begin
						left_q  <= klen;
						ktot_q  <= klen;
						raddr_q <= kfirst;
					end else begin
						rdtime_s1 <= 1'b1;
						rslot_s1  <= raddr_q;
						raddr_q   <= raddr_q + 1'b1;
						left_q    <= left_q - 1'b1;
					end
				end
				ST_CSCAN: if (left_q != '0) begin
					rdtime_s1 <= 1'b0;
					raddr_q   <= raddr_q + 1'b1;
					left_q    <= left_q - 1'b1;
				end
				ST_DIV: begin
					if (!dbusy_q) dbusy_q <= 1'b1;
					if (ddone) begin
						dbusy_q <= 1'b0;
						if (!last_issue) didx_q <= didx_q + 1'b1;
					end
				end
				ST_OUT1: if (out_ready) begin
					didx_q <= '0;
					// keep the time window anchor off the slot being overwritten
					if (stored_q[TallyW-1] && nstart_q == wslot_q) begin
						tstart_q <= nstart_q + 1'b1;
					end else begin
						tstart_q <= nstart_q;
					end
					wslot_q <= wslot_q + 1'b1;
					if (!stored_q[TallyW-1]) stored_q <= stored_q + 1'b1;
				end
				default: ;
			endcase
			if (rd_s1 && rdtime_s1 && in_tw && !found_q) begin
				found_q  <= 1'b1;
				nstart_q <= rslot_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			cur_q <= wdata;
			tw_q  <= '0;
			cw_q  <= '0;
		end
		if (rd_s1) begin
			if (rdtime_s1) begin
				if (in_tw) tw_q <= tally_add(tw_q, rdata, cur_q, same_host, same_port,
					same_src, other_q);
			end else begin
				cw_q <= tally_add(cw_q, rdata, cur_q, same_host, same_port,
					same_src, other_q);
			end
		end
		if (state_q == ST_DIV && ddone) begin
			rate_q[didx_q] <= dquot;
		end
	end

	// result mapping: slots 0..6 time set, 7 same source, 8..14 count set
	function automatic logic [CountW-1:0] sat_count(logic [TallyW-1:0] v);
		return (v > TallyW'(1023)) ? CountW'(1023) : v[CountW-1:0];
	endfunction

	logic sel1;
	assign sel1 = state_q == ST_OUT1;

	assign out_valid           = (state_q == ST_OUT0) || sel1;
	assign window_kind         = sel1;
	assign last_of_run         = sel1;
	assign host_count          = sel1 ? sat_count(cw_q.host) : sat_count(tw_q.host);
	assign port_count          = sel1 ? sat_count(cw_q.port) : sat_count(tw_q.port);
	assign syn_error_rate      = sel1 ? rate_q[8]  : rate_q[0];
	assign port_syn_error_rate = sel1 ? rate_q[9]  : rate_q[1];
	assign reject_rate         = sel1 ? rate_q[10] : rate_q[2];
	assign port_reject_rate    = sel1 ? rate_q[11] : rate_q[3];
	assign same_service_rate   = sel1 ? rate_q[12] : rate_q[4];
	assign diff_service_rate   = sel1 ? rate_q[13] : rate_q[5];
	assign port_diff_host_rate = sel1 ? rate_q[14] : rate_q[6];
	assign src_port_match_rate = sel1 ? rate_q[7]  : '0;

endmodule

FILE: design/cwtf_checker.sv
// ============================================================================
// cwtf_checker
// Port-level checks on the traffic feature unit, bound to the top level.
// ============================================================================
module cwtf_checker
	import cwtf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic window_kind,
	input logic last_of_run,
	input logic [CountW-1:0] host_count
);

	a_kind_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (window_kind == last_of_run))
		else $error("window kind and last flag disagree");

	a_no_accept_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready while results pending");

	a_one_record: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input ready again straight after a transfer");

	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_of_run) |=> (out_valid && last_of_run))
		else $error("second result of pair missing");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(host_count)))
		else $error("result changed while stalled");

endmodule

bind connection_window_traffic_features_unit cwtf_checker u_cwtf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.window_kind (window_kind),
	.last_of_run (last_of_run),
	.host_count  (host_count)
);
